// File: design/utf8sd_pkg.sv
`default_nettype none
package utf8sd_pkg;

	localparam int unsigned CP_W      = 21;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned PART_W    = 15;
	localparam int unsigned CNT_W     = 2;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW   = $clog2(FIFO_DEPTH);

	localparam logic [CP_W-1:0] REPL_RESET = 21'h00FFFD;
	localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;
	localparam logic [CP_W-1:0] MIN_LEN2   = 21'h000080;
	localparam logic [CP_W-1:0] MIN_LEN3   = 21'h000800;
	localparam logic [CP_W-1:0] MIN_LEN4   = 21'h010000;

	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_2    = 3'd2;
	localparam logic [2:0] LEN_3    = 3'd3;
	localparam logic [2:0] LEN_4    = 3'd4;

	// One classified byte: cnt results, all replacements except possibly the last.
	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic [CP_W-1:0]  value;
		logic             last_rep;
	} desc_t;

endpackage
`default_nettype wire

// File: design/utf8sd_intf.sv
`default_nettype none
interface utf8sd_byte_if;
	logic                           valid;
	logic                           ready;
	logic [utf8sd_pkg::BYTE_W-1:0]  data_byte;
	logic                           end_of_buffer;
	modport source (output valid, data_byte, end_of_buffer, input ready);
	modport sink (input valid, data_byte, end_of_buffer, output ready);
endinterface

interface utf8sd_code_if;
	logic                         valid;
	logic                         ready;
	logic [utf8sd_pkg::CP_W-1:0]  code_point;
	logic                         is_replacement;
	logic                         last_of_run;
	modport source (output valid, code_point, is_replacement, last_of_run, input ready);
	modport sink (input valid, code_point, is_replacement, last_of_run, output ready);
endinterface

interface utf8sd_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [utf8sd_pkg::CP_W-1:0]  replacement_code;
	modport source (output valid, replacement_code, input ready);
	modport sink (input valid, replacement_code, output ready);
endinterface
`default_nettype wire

// File: design/utf8sd_front.sv
`default_nettype none
module utf8sd_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	utf8sd_byte_if.sink            bytes,
	input  wire logic              q_full,
	output utf8sd_pkg::desc_t      push_desc,
	output logic                   push
);

	typedef enum logic [2:0] {
		LC_ASCII,
		LC_LEAD2,
		LC_LEAD3,
		LC_LEAD4,
		LC_INVALID
	} lead_class_t;

	logic [2:0]                      seq_len_q;
	logic [1:0]                      cont_q;
	logic [utf8sd_pkg::PART_W-1:0]   partial_q;

	lead_class_t                     lclass;
	logic                            accept;
	logic                            pending;
	logic                            is_cont;
	logic                            complete;
	logic                            bad;
	logic [utf8sd_pkg::CP_W-1:0]     v;
	logic [utf8sd_pkg::CP_W-1:0]     minv;
	logic [1:0]                      pre;
	logic [2:0]                      seq_len_d;
	logic [1:0]                      cont_d;
	logic [utf8sd_pkg::PART_W-1:0]   partial_d;
	utf8sd_pkg::desc_t               d;

	assign bytes.ready = !q_full;
	assign accept      = bytes.valid && !q_full;
	assign pending     = (seq_len_q != utf8sd_pkg::LEN_NONE);
	assign is_cont     = (bytes.data_byte[7:6] == 2'b10);
	assign v           = {partial_q, bytes.data_byte[5:0]};
	assign complete    = ({1'b0, cont_q} + 3'd2) >= seq_len_q;
	assign pre         = pending ? 2'd1 : 2'd0;

	always_comb begin
		if (bytes.data_byte[7] == 1'b0) begin
			lclass = LC_ASCII;
		end else if (bytes.data_byte[7:5] == 3'b110) begin
			lclass = LC_LEAD2;
		end else if (bytes.data_byte[7:4] == 4'b1110) begin
			lclass = LC_LEAD3;
		end else if (bytes.data_byte[7:3] == 5'b11110) begin
			lclass = LC_LEAD4;
		end else begin
			lclass = LC_INVALID;
		end
	end

	always_comb begin
		unique case (seq_len_q)
			utf8sd_pkg::LEN_2: minv = utf8sd_pkg::MIN_LEN2;
			utf8sd_pkg::LEN_3: minv = utf8sd_pkg::MIN_LEN3;
			default:           minv = utf8sd_pkg::MIN_LEN4;
		endcase
		bad = (v < minv) || ((v >= utf8sd_pkg::SURR_LO) && (v <= utf8sd_pkg::SURR_HI))
			|| (v > utf8sd_pkg::CP_MAX);
	end

	always_comb begin
		d          = '0;
		seq_len_d  = utf8sd_pkg::LEN_NONE;
		cont_d     = 2'd0;
		partial_d  = '0;
		if (pending && is_cont) begin
			if (complete) begin
				d.cnt      = 2'd1;
				d.value    = v;
				d.last_rep = bad;
			end else if (bytes.end_of_buffer) begin
				// Truncated: one replacement for the lead and one per continuation.
				d.cnt      = cont_q + 2'd2;
				d.last_rep = 1'b1;
			end else begin
				seq_len_d = seq_len_q;
				cont_d    = cont_q + 2'd1;
				partial_d = v[utf8sd_pkg::PART_W-1:0];
			end
		end else begin
			// A broken sequence costs one replacement before the new byte.
			d.last_rep = 1'b1;
			unique case (lclass)
				LC_ASCII: begin
					d.cnt      = pre + 2'd1;
					d.value    = {{(utf8sd_pkg::CP_W-utf8sd_pkg::BYTE_W){1'b0}},
						bytes.data_byte};
					d.last_rep = 1'b0;
				end
				LC_LEAD2, LC_LEAD3, LC_LEAD4: begin
					if (bytes.end_of_buffer) begin
						d.cnt = pre + 2'd1;
					end else begin
						d.cnt = pre;
						unique case (lclass)
							LC_LEAD2: begin
								seq_len_d = utf8sd_pkg::LEN_2;
								partial_d = {10'd0, bytes.data_byte[4:0]};
							end
							LC_LEAD3: begin
								seq_len_d = utf8sd_pkg::LEN_3;
								partial_d = {11'd0, bytes.data_byte[3:0]};
							end
							default: begin
								seq_len_d = utf8sd_pkg::LEN_4;
								partial_d = {12'd0, bytes.data_byte[2:0]};
							end
						endcase
					end
				end
				default: begin
					d.cnt = pre + 2'd1;
				end
			endcase
		end
	end

	assign push      = accept && (d.cnt != 2'd0);
	assign push_desc = d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_len_q <= utf8sd_pkg::LEN_NONE;
			cont_q    <= 2'd0;
			partial_q <= '0;
		end else if (accept) begin
			seq_len_q <= seq_len_d;
			cont_q    <= cont_d;
			partial_q <= partial_d;
		end
	end

endmodule
`default_nettype wire

// File: design/utf8sd_fifo.sv
`default_nettype none
module utf8sd_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire utf8sd_pkg::desc_t push_desc,
	input  wire logic              pop,
	output utf8sd_pkg::desc_t      head,
	output logic                   empty,
	output logic                   full
);

	utf8sd_pkg::desc_t                mem_q [utf8sd_pkg::FIFO_DEPTH];
	logic [utf8sd_pkg::FIFO_AW-1:0]   wr_q;
	logic [utf8sd_pkg::FIFO_AW-1:0]   rd_q;
	logic [utf8sd_pkg::FIFO_AW:0]     count_q;
	logic                             do_pop;

	assign empty  = (count_q == '0);
	assign full   = (count_q == (utf8sd_pkg::FIFO_AW+1)'(utf8sd_pkg::FIFO_DEPTH));
	assign head   = mem_q[rd_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: design/utf8sd_back.sv
`default_nettype none
module utf8sd_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire utf8sd_pkg::desc_t         head,
	input  wire logic                      empty,
	input  wire logic [utf8sd_pkg::CP_W-1:0] repl,
	output logic                           pop,
	utf8sd_code_if.source                  codes
);

	logic [utf8sd_pkg::CNT_W-1:0]   idx_q;
	logic                           out_valid_q;
	logic [utf8sd_pkg::CP_W-1:0]    code_q;
	logic                           rep_q;
	logic                           last_q;
	logic                           advance;
	logic                           is_last;
	logic                           use_value;

	assign advance   = !empty && (!out_valid_q || codes.ready);
	assign is_last   = (idx_q == (head.cnt - 2'd1));
	assign use_value = is_last && !head.last_rep;
	assign pop       = advance && is_last;

	assign codes.valid          = out_valid_q;
	assign codes.code_point     = code_q;
	assign codes.is_replacement = rep_q;
	assign codes.last_of_run    = last_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			code_q <= use_value ? head.value : repl;
			rep_q  <= !use_value;
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? '0 : idx_q + 1'b1;
			end else if (codes.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: design/utf8_stream_decoder.sv
// Timing: a byte's first result is registered in the descriptor queue and then in the
// output stage before codes.valid rises for it.
// Throughput: one byte per cycle; one result transaction per cycle while codes.ready is high,
// so a byte that causes two or three results holds the back end for one transaction each,
// and a four-entry descriptor queue absorbs the difference before the byte input stalls.
// Reset (arst_n low, asynchronous): no sequence pending, queue empty, output idle,
// and the replacement code returns to U+FFFD.
`default_nettype none
module utf8_stream_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	utf8sd_byte_if.sink      bytes,
	utf8sd_code_if.source    codes,
	utf8sd_cfg_if.sink       cfg
);

	// The replacement code register. Software must write it only while the decoder is idle, so
	// that the back end may read it when a result is formed; the block does not enforce this.
	logic [utf8sd_pkg::CP_W-1:0] repl_q;

	// Descriptor traffic between the front end, the queue and the back end.
	utf8sd_pkg::desc_t push_desc;
	utf8sd_pkg::desc_t head;
	logic              push;
	logic              pop;
	logic              empty;
	logic              full;

	// Configuration writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q <= utf8sd_pkg::REPL_RESET;
		end else if (cfg.valid) begin
			repl_q <= cfg.replacement_code;
		end
	end

	// The front end holds the pending sequence state and turns each accepted byte
	// into one descriptor: how many results it causes and the value of the last.
	// Every earlier result of the same byte is a replacement. A byte that causes
	// no result only updates the sequence state and queues nothing.
	utf8sd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.bytes     (bytes),
		.q_full    (full),
		.push_desc (push_desc),
		.push      (push)
	);

	// A short queue lets the front end keep taking bytes while the back end
	// expands a multi-result descriptor or waits on a stalled output.
	utf8sd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	// The back end walks the head descriptor one result per transaction into a
	// registered output stage and marks the final result of each byte.
	utf8sd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.repl   (repl_q),
		.pop    (pop),
		.codes  (codes)
	);

endmodule
`default_nettype wire

// File: tb/sv/utf8sd_code_checker.sv
module utf8sd_code_checker
	import utf8sd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	utf8sd_byte_if      bytes,
	utf8sd_code_if      codes,
	utf8sd_cfg_if       cfg,
	output int unsigned mismatches,
	output int unsigned in_flight
);

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            is_replacement;
		logic            last_of_run;
	} code_t;

	code_t           expected_codes [$];
	logic [CP_W-1:0] repl_code;
	logic [2:0]      seq_len;
	logic [1:0]      conts_seen;
	logic [CP_W-1:0] partial_cp;

	function automatic code_t code_result(input logic [CP_W-1:0] cp, input logic rep);
		code_t r;
		r.code_point     = cp;
		r.is_replacement = rep;
		r.last_of_run    = 1'b0;
		return r;
	endfunction

	// Decodes one accepted byte against the running sequence state and queues
	// every code point it produces, flagging the final one of the run.
	function automatic void decode_byte(input logic [7:0] b, input logic eob);
		code_t           run [$];
		code_t           tail;
		logic [CP_W-1:0] v;
		logic [CP_W-1:0] floor_cp;
		logic [CP_W-1:0] new_val;
		logic [2:0]      seen;
		logic [2:0]      new_len;
		logic            pending;
		pending = (seq_len != LEN_NONE);
		if (pending && b[7:6] == 2'b10) begin
			v    = {partial_cp[CP_W-7:0], b[5:0]};
			seen = {1'b0, conts_seen} + 3'd1;
			if (seen + 3'd1 >= seq_len) begin
				floor_cp = (seq_len == LEN_2) ? MIN_LEN2 :
				           (seq_len == LEN_3) ? MIN_LEN3 : MIN_LEN4;
				if (v < floor_cp || (v >= SURR_LO && v <= SURR_HI) || v > CP_MAX) begin
					run.push_back(code_result(repl_code, 1'b1));
				end else begin
					run.push_back(code_result(v, 1'b0));
				end
				seq_len    = LEN_NONE;
				conts_seen = '0;
				partial_cp = '0;
			end else if (eob) begin
				// One replacement for the lead and one per collected continuation.
				repeat (int'(seen) + 1) run.push_back(code_result(repl_code, 1'b1));
				seq_len    = LEN_NONE;
				conts_seen = '0;
				partial_cp = '0;
			end else begin
				partial_cp = v;
				conts_seen = seen[1:0];
			end
		end else begin
			if (pending) begin
				run.push_back(code_result(repl_code, 1'b1));
			end
			seq_len    = LEN_NONE;
			conts_seen = '0;
			partial_cp = '0;
			new_len    = LEN_NONE;
			new_val    = '0;
			if (b[7] == 1'b0) begin
				run.push_back(code_result({13'b0, b}, 1'b0));
			end else if (b[7:5] == 3'b110) begin
				new_len = LEN_2;
				new_val = CP_W'(b[4:0]);
			end else if (b[7:4] == 4'b1110) begin
				new_len = LEN_3;
				new_val = CP_W'(b[3:0]);
			end else if (b[7:3] == 5'b11110) begin
				new_len = LEN_4;
				new_val = CP_W'(b[2:0]);
			end else begin
				run.push_back(code_result(repl_code, 1'b1));
			end
			if (new_len != LEN_NONE) begin
				if (eob) begin
					run.push_back(code_result(repl_code, 1'b1));
				end else begin
					seq_len    = new_len;
					partial_cp = new_val;
				end
			end
		end
		if (run.size() != 0) begin
			tail = run.pop_back();
			tail.last_of_run = 1'b1;
			run.push_back(tail);
		end
		foreach (run[i]) expected_codes.push_back(run[i]);
	endfunction

	task automatic report_mismatch(input string what, input logic [CP_W-1:0] got,
			input logic [CP_W-1:0] want);
		$display("mismatch at %0t: %s: got %h, expected %h", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		code_t want;
		if (!arst_n) begin
			repl_code  = REPL_RESET;
			seq_len    = LEN_NONE;
			conts_seen = '0;
			partial_cp = '0;
			mismatches = 0;
			expected_codes.delete();
			in_flight <= 0;
		end else begin
			if (codes.valid && codes.ready) begin
				if (expected_codes.size() == 0) begin
					report_mismatch("code point with nothing expected", codes.code_point, '0);
				end else begin
					want = expected_codes.pop_front();
					if (codes.code_point !== want.code_point)
						report_mismatch("code_point", codes.code_point, want.code_point);
					if (codes.is_replacement !== want.is_replacement)
						report_mismatch("is_replacement", CP_W'(codes.is_replacement),
							CP_W'(want.is_replacement));
					if (codes.last_of_run !== want.last_of_run)
						report_mismatch("last_of_run", CP_W'(codes.last_of_run),
							CP_W'(want.last_of_run));
				end
			end
			if (cfg.valid && cfg.ready) begin
				repl_code = cfg.replacement_code;
			end
			if (bytes.valid && bytes.ready) begin
				decode_byte(bytes.data_byte, bytes.end_of_buffer);
			end
			in_flight <= expected_codes.size();
		end
	end

endmodule

// File: tb/sv/testbench.sv
// Top of the decoder testbench. It drives the byte channel and the replacement
// code register, paces the code point channel, and gives the verdict. All
// prediction and comparison lives in the checker instantiated beside the block.
module testbench;
	import utf8sd_pkg::*;

	// Random items per phase, counted in bytes.
	localparam int unsigned PHASE_ITEMS = 32;
	// Length of the long receiver hold in the pressure phase.
	localparam int unsigned LONG_HOLD = 300;
	// Cycles without any transaction before the run is declared hung.
	localparam int unsigned QUIET_LIMIT = 5000;
	// Cycles waited after the predictions drain, to cover a byte that is still
	// in flight but produces nothing.
	localparam int unsigned DRAIN_CYCLES = 4;

	// Directed bytes, written as {end_of_buffer, data_byte}.
	localparam logic [8:0] DIRECTED [25] = '{
		9'h000, 9'h17F,          // ASCII extremes, the second one ending a buffer
		9'h0C2, 9'h080,          // smallest two-byte code point
		9'h0DF, 9'h0BF,          // largest two-byte code point
		9'h080,                  // stray continuation
		9'h0FF, 9'h0F8,          // bytes that can never start a sequence
		9'h0E0, 9'h0A0, 9'h041,  // sequence broken by an ASCII byte
		9'h0F0, 9'h090, 9'h180,  // four-byte sequence cut short by end of buffer
		9'h1C2,                  // lead byte arriving with end of buffer
		9'h0ED, 9'h0A0, 9'h080,  // surrogate
		9'h0F4, 9'h090, 9'h080, 9'h080, // above the code space
		9'h0C0, 9'h080           // overlong lead
	};

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned send_idle_pct;
	int unsigned stall_pct;
	int unsigned hold_requests;
	int unsigned items_sent;
	int unsigned mismatches;
	int unsigned in_flight;

	utf8sd_byte_if bytes_ch ();
	utf8sd_code_if codes_ch ();
	utf8sd_cfg_if  cfg_ch ();

	utf8_stream_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes_ch),
		.codes  (codes_ch),
		.cfg    (cfg_ch)
	);

	utf8sd_code_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.bytes      (bytes_ch),
		.codes      (codes_ch),
		.cfg        (cfg_ch),
		.mismatches (mismatches),
		.in_flight  (in_flight)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Offers one byte, idling beforehand at the phase's rate, and returns at the
	// edge where the transaction completes. Valid is left high so that a
	// following byte goes out back to back.
	task automatic send_byte(input logic [7:0] b, input logic eob);
		while ($urandom_range(99) < send_idle_pct) begin
			bytes_ch.valid <= 1'b0;
			@(posedge clk);
		end
		bytes_ch.valid         <= 1'b1;
		bytes_ch.data_byte     <= b;
		bytes_ch.end_of_buffer <= eob;
		@(posedge clk);
		while (!bytes_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	// Builds one short burst of bytes. Most bursts are complete sequences with
	// random payload bits; some lose their tail and are either cut by end of
	// buffer or broken by a fresh byte; the rest is plain noise. Three- and
	// four-byte leads lean toward the surrogate and upper-range leads so that
	// those rejections come up often.
	task automatic send_random_sequence();
		logic [7:0]  burst [$];
		logic [7:0]  breaker;
		int unsigned kind;
		int unsigned span;
		int unsigned keep;
		logic        cut;
		logic        eob;
		kind = $urandom_range(99);
		cut  = 1'b0;
		if (kind < 25) begin
			burst.push_back({1'b0, 7'($urandom_range(127))});
		end else if (kind < 90) begin
			span = $urandom_range(2, 4);
			case (span)
				2: begin
					burst.push_back({3'b110, 5'($urandom_range(31))});
				end
				3: begin
					burst.push_back(($urandom_range(3) == 0) ? 8'hED :
						{4'b1110, 4'($urandom_range(15))});
				end
				default: begin
					burst.push_back(($urandom_range(3) == 0) ? 8'hF4 :
						{5'b11110, 3'($urandom_range(7))});
				end
			endcase
			repeat (span - 1) burst.push_back({2'b10, 6'($urandom_range(63))});
			if (kind >= 78) begin
				// Drop at least one continuation, then either break the
				// sequence with a non-continuation byte or end the buffer.
				keep = $urandom_range(1, span - 1);
				while (burst.size() > keep) void'(burst.pop_back());
				if ($urandom_range(1) == 1) begin
					breaker = 8'($urandom_range(255));
					if (breaker[7:6] == 2'b10) breaker[6] = 1'b1;
					burst.push_back(breaker);
				end else begin
					cut = 1'b1;
				end
			end
		end else begin
			burst.push_back(8'($urandom_range(255)));
		end
		eob = cut || ($urandom_range(9) == 0);
		foreach (burst[i]) send_byte(burst[i], eob && (i == burst.size() - 1));
	endtask

	// Stops offering bytes and waits until every predicted code point has come
	// back, then lets the pipeline drain before anything else happens.
	task automatic settle();
		bytes_ch.valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_replacement(input logic [CP_W-1:0] value);
		settle();
		cfg_ch.valid            <= 1'b1;
		cfg_ch.replacement_code <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_phase(input int unsigned count, input int unsigned idle,
			input int unsigned stall);
		int unsigned target;
		send_idle_pct = idle;
		stall_pct     = stall;
		target        = items_sent + count;
		while (items_sent < target) send_random_sequence();
	endtask

	// Receiver side. It stalls at the phase's rate and, when the stimulus asks,
	// holds ready low for a long stretch counted here, so that the block's
	// result queue fills and it stops taking bytes.
	initial begin
		int unsigned holds_done;
		holds_done = 0;
		codes_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done != hold_requests) begin
				holds_done++;
				codes_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			codes_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog: the run is hung if no transaction of any kind completes for a
	// long time. The limit is many times the longest legal quiet stretch, which
	// is the long receiver hold.
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((bytes_ch.valid === 1'b1 && bytes_ch.ready === 1'b1) ||
			    (codes_ch.valid === 1'b1 && codes_ch.ready === 1'b1) ||
			    (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("testbench: errors");
		$finish;
	end

	initial begin
		arst_n                  <= 1'b0;
		bytes_ch.valid          <= 1'b0;
		bytes_ch.data_byte      <= '0;
		bytes_ch.end_of_buffer  <= 1'b0;
		cfg_ch.valid            <= 1'b0;
		cfg_ch.replacement_code <= '0;
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_requests = 0;
		items_sent    = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed bytes run with the reset replacement code and no idling.
		foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

		// Each phase changes the replacement code, covering both ends of its
		// range and every bit in both states, and uses its own idling pattern.
		write_replacement('0);
		run_phase(PHASE_ITEMS, 0, 0);
		write_replacement(CP_MAX);
		run_phase(PHASE_ITEMS, 67, 0);
		write_replacement(21'h0FFFFF);
		run_phase(PHASE_ITEMS, 0, 67);
		write_replacement(CP_W'($urandom_range(32'(CP_MAX))));
		run_phase(PHASE_ITEMS, 26, 26);

		// Back-pressure: the receiver goes quiet for a long stretch while bytes
		// keep coming with no gaps.
		write_replacement(REPL_RESET);
		hold_requests++;
		run_phase(24, 0, 0);

		settle();
		if (mismatches == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
